// ===== rtl/v3alu_pkg.sv =====
// Shared types, widths and opcodes of the three-component vector unit.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package v3alu_pkg;

    // word format of every vector component
    localparam int WW       = 32;
    localparam int FRAC_DEF = 16;
    localparam int LW       = WW - 1;     // length field width
    localparam int SW       = 2 * WW;     // sum of squares width
    localparam int NW       = 128;        // normalized radicand width
    localparam int RW       = NW / 2;     // square root width
    localparam int KW       = 6;          // half-shift count, 0..RW-1

    // opcodes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_SCALE = 3'd3;
    localparam logic [2:0] OP_NORM  = 3'd4;
    localparam logic [2:0] OP_CROSS = 3'd5;
    localparam logic [2:0] OP_LEN   = 3'd6;

    // input request
    typedef struct packed {
        logic [2:0]           opcode;
        logic signed [WW-1:0] ax;
        logic signed [WW-1:0] ay;
        logic signed [WW-1:0] az;
        logic signed [WW-1:0] bx;
        logic signed [WW-1:0] by;
        logic signed [WW-1:0] bz;
        logic signed [WW-1:0] scale;
    } req_t;

    // result
    typedef struct packed {
        logic signed [WW-1:0] rx;
        logic signed [WW-1:0] ry;
        logic signed [WW-1:0] rz;
        logic [LW-1:0]        length;
        logic                 zero_length_error;
    } rsp_t;

    // per-item side data carried along the root and divide pipelines
    typedef struct packed {
        logic [2:0]           opcode;
        logic [2:0]           neg;    // sign of each A component
        logic [2:0][WW-1:0]   mag;    // magnitude of each A component
        logic [KW-1:0]        k;      // radicand was shifted left by 2k
        logic                 zero;   // sum of squares is zero
        logic [2:0][WW-1:0]   vec;    // finished result of non-normalize ops
    } mid_t;

endpackage

`default_nettype wire

// ===== rtl/v3alu_front.sv =====
// Front end: multipliers, rounding/saturation of the simple ops, sum of
// squares, leading-zero count and radicand normalization. Uses v3alu_pkg.
`default_nettype none

module v3alu_front #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic                        req_valid,
    input  wire v3alu_pkg::req_t             req,
    output logic                             stg_valid,
    output logic [v3alu_pkg::NW-1:0]         stg_rad,
    output v3alu_pkg::mid_t                  stg_mid
);

    localparam int WW = v3alu_pkg::WW;
    localparam int SW = v3alu_pkg::SW;
    localparam int NW = v3alu_pkg::NW;
    localparam int KW = v3alu_pkg::KW;
    localparam int ZW = 8;
    localparam logic signed [SW+1:0] HALF = (SW+2)'(1) << (FRAC_BITS - 1);

    // round-free saturation to the signed word
    function automatic logic [WW-1:0] sat_w(input logic signed [SW+1:0] v);
        logic [WW-1:0] r;
        if ((v[SW+1:WW-1] == '0) || (v[SW+1:WW-1] == '1))
            r = v[WW-1:0];
        else if (v[SW+1])
            r = {1'b1, {(WW-1){1'b0}}};
        else
            r = {1'b0, {(WW-1){1'b1}}};
        return r;
    endfunction

    // leading zeros of the sum of squares
    function automatic logic [ZW-1:0] lzc(input logic [SW-1:0] s);
        logic [ZW-1:0] n;
        n = ZW'(SW);
        for (int i = 0; i < SW; i++)
            if (s[i])
                n = ZW'(SW - 1 - i);
        return n;
    endfunction

    // ---------------- stage 1: products and sums ----------------
    logic signed [WW-1:0] a [3];
    logic signed [WW-1:0] b [3];
    logic signed [WW-1:0] ma [3];
    logic signed [WW-1:0] mb [3];
    logic signed [WW-1:0] na [3];
    logic signed [WW-1:0] nb [3];

    logic                 v1_reg;
    logic [2:0]           op1_reg;
    logic signed [SW-1:0] p1_reg [3];
    logic signed [SW-1:0] p2_reg [3];
    logic signed [SW-1:0] sq_reg [3];
    logic signed [WW:0]   as_reg [3];
    logic signed [WW-1:0] a1_reg [3];

    // operand selection per opcode
    always_comb
    begin
        a[0] = req.ax; a[1] = req.ay; a[2] = req.az;
        b[0] = req.bx; b[1] = req.by; b[2] = req.bz;
        for (int c = 0; c < 3; c++)
        begin
            ma[c] = a[c];
            mb[c] = b[c];
            na[c] = '0;
            nb[c] = '0;
        end
        case (req.opcode)
            v3alu_pkg::OP_SCALE:
            begin
                for (int c = 0; c < 3; c++)
                    mb[c] = req.scale;
            end
            v3alu_pkg::OP_CROSS:
            begin
                ma[0] = a[1]; mb[0] = b[2]; na[0] = a[2]; nb[0] = b[1];
                ma[1] = a[2]; mb[1] = b[0]; na[1] = a[0]; nb[1] = b[2];
                ma[2] = a[0]; mb[2] = b[1]; na[2] = a[1]; nb[2] = b[0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (advance)
            v1_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op1_reg <= req.opcode;
            for (int c = 0; c < 3; c++)
            begin
                p1_reg[c] <= ma[c] * mb[c];
                p2_reg[c] <= na[c] * nb[c];
                sq_reg[c] <= a[c] * a[c];
                as_reg[c] <= (req.opcode == v3alu_pkg::OP_SUB)
                           ? ({a[c][WW-1], a[c]} - {b[c][WW-1], b[c]})
                           : ({a[c][WW-1], a[c]} + {b[c][WW-1], b[c]});
                a1_reg[c] <= a[c];
            end
        end
    end

    // ---------------- stage 2: round, saturate, sum of squares ----------------
    logic signed [SW:0]   d [3];
    logic signed [SW+1:0] rd [3];
    logic signed [SW+1:0] sh [3];
    logic [WW-1:0]        vec_next [3];

    logic                 v2_reg;
    logic [SW-1:0]        s2_reg;
    v3alu_pkg::mid_t      m2_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            d[c]  = {p1_reg[c][SW-1], p1_reg[c]} - {p2_reg[c][SW-1], p2_reg[c]};
            rd[c] = {d[c][SW], d[c]} + HALF;
            sh[c] = rd[c] >>> FRAC_BITS;
            case (op1_reg)
                v3alu_pkg::OP_ADD,
                v3alu_pkg::OP_SUB:
                    vec_next[c] = sat_w({{(SW+1-WW){as_reg[c][WW]}}, as_reg[c]});
                v3alu_pkg::OP_MUL,
                v3alu_pkg::OP_SCALE,
                v3alu_pkg::OP_CROSS:
                    vec_next[c] = sat_w(sh[c]);
                default:
                    vec_next[c] = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (advance)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            m2_reg.opcode <= op1_reg;
            m2_reg.k      <= '0;
            m2_reg.zero   <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                m2_reg.neg[c] <= a1_reg[c][WW-1];
                m2_reg.mag[c] <= a1_reg[c][WW-1] ? (~a1_reg[c] + 1'b1) : a1_reg[c];
                m2_reg.vec[c] <= vec_next[c];
            end
        end
    end

    // ---------------- stage 3: leading-zero count ----------------
    logic [ZW-1:0]   lz_tot;
    logic            v3_reg;
    logic [SW-1:0]   s3_reg;
    v3alu_pkg::mid_t m3_reg;
    v3alu_pkg::mid_t m3_next;

    assign lz_tot = ZW'(NW - SW) + lzc(s2_reg);

    // side data with shift count and zero flag filled in
    always_comb
    begin
        m3_next      = m2_reg;
        m3_next.k    = lz_tot[KW:1];
        m3_next.zero = (s2_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (advance)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_reg <= s2_reg;
            m3_reg <= m3_next;
        end
    end

    // ---------------- stage 4: even left shift of the radicand ----------------
    logic            v4_reg;
    logic [NW-1:0]   rad4_reg;
    v3alu_pkg::mid_t m4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (advance)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rad4_reg <= {{(NW-SW){1'b0}}, s3_reg} << {m3_reg.k, 1'b0};
            m4_reg   <= m3_reg;
        end
    end

    assign stg_valid = v4_reg;
    assign stg_rad   = rad4_reg;
    assign stg_mid   = m4_reg;

endmodule

`default_nettype wire

// ===== rtl/v3alu_sqrt.sv =====
// Integer square root of the normalized radicand, one root bit per stage.
// Uses v3alu_pkg for widths and the side-data struct.
`default_nettype none

module v3alu_sqrt (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire logic                   stg_valid,
    input  wire logic [v3alu_pkg::NW-1:0] stg_rad,
    input  wire v3alu_pkg::mid_t        stg_mid,
    output logic                        root_valid,
    output logic [v3alu_pkg::RW-1:0]    root,
    output v3alu_pkg::mid_t             root_mid
);

    localparam int NW = v3alu_pkg::NW;
    localparam int RW = v3alu_pkg::RW;

    logic                 vld_reg  [RW];
    logic [NW-1:0]        rad_reg  [RW];
    logic [RW-1:0]        rem_reg  [RW];
    logic [RW-1:0]        root_reg [RW];
    v3alu_pkg::mid_t      mid_reg  [RW];

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic            pv;
        logic [NW-1:0]   prad;
        logic [RW-1:0]   prem;
        logic [RW-1:0]   proot;
        v3alu_pkg::mid_t pmid;
        logic [RW+1:0]   rem_sh;
        logic [RW+1:0]   trial;
        logic            ge;

        if (i == 0)
        begin : g_first
            assign pv    = stg_valid;
            assign prad  = stg_rad;
            assign prem  = '0;
            assign proot = '0;
            assign pmid  = stg_mid;
        end
        else
        begin : g_next
            assign pv    = vld_reg[i-1];
            assign prad  = rad_reg[i-1];
            assign prem  = rem_reg[i-1];
            assign proot = root_reg[i-1];
            assign pmid  = mid_reg[i-1];
        end

        // bring down two radicand bits, try root*4+1
        assign rem_sh = {prem, prad[NW-1-2*i -: 2]};
        assign trial  = {proot, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (advance)
                vld_reg[i] <= pv;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rad_reg[i]  <= prad;
                rem_reg[i]  <= ge ? RW'(rem_sh - trial) : rem_sh[RW-1:0];
                root_reg[i] <= {proot[RW-2:0], ge};
                mid_reg[i]  <= pmid;
            end
        end
    end

    assign root_valid = vld_reg[RW-1];
    assign root       = root_reg[RW-1];
    assign root_mid   = mid_reg[RW-1];

endmodule

`default_nettype wire

// ===== rtl/v3alu_div.sv =====
// Normalize back end: length extraction, per-component restoring divide by
// the root, rounding, sign and saturation, result assembly. Uses v3alu_pkg.
`default_nettype none

module v3alu_div #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire logic                   root_valid,
    input  wire logic [v3alu_pkg::RW-1:0] root,
    input  wire v3alu_pkg::mid_t        root_mid,
    output logic                        res_valid,
    output v3alu_pkg::rsp_t             res
);

    localparam int WW = v3alu_pkg::WW;
    localparam int LW = v3alu_pkg::LW;
    localparam int RW = v3alu_pkg::RW;
    localparam int QW = FRAC_BITS + 1;              // quotient bits, value <= 2^F
    localparam int CW = (QW + 1 > WW) ? QW + 1 : WW;
    localparam logic [CW:0] MAGP = ((CW+1)'(1) << (WW - 1)) - (CW+1)'(1);
    localparam logic [CW:0] MAGN = (CW+1)'(1) << (WW - 1);

    // ---------------- setup: length and dividends ----------------
    logic [RW-1:0]   lsh;
    logic            sv_reg;
    logic [RW-1:0]   sl_reg;
    logic [RW-1:0]   sx_reg [3];
    logic [LW-1:0]   slen_reg;
    v3alu_pkg::mid_t smid_reg;

    assign lsh = root >> root_mid.k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg <= 1'b0;
        else if (advance)
            sv_reg <= root_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sl_reg   <= root;
            smid_reg <= root_mid;
            slen_reg <= (lsh[RW-1:LW] != '0) ? {LW{1'b1}} : lsh[LW-1:0];
            for (int c = 0; c < 3; c++)
                sx_reg[c] <= {{(RW-WW){1'b0}}, root_mid.mag[c]} << root_mid.k;
        end
    end

    // ---------------- divide: one quotient bit per stage ----------------
    logic            dv_reg   [QW];
    logic [RW-1:0]   dl_reg   [QW];
    logic [LW-1:0]   dlen_reg [QW];
    v3alu_pkg::mid_t dmid_reg [QW];
    logic [RW-1:0]   drem_reg [QW][3];
    logic [QW-1:0]   dq_reg   [QW][3];

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        logic            pv;
        logic [RW-1:0]   pl;
        logic [LW-1:0]   plen;
        v3alu_pkg::mid_t pmid;
        logic [RW-1:0]   prem [3];
        logic [QW-1:0]   pq   [3];
        logic [RW:0]     t    [3];
        logic            ge   [3];

        if (j == 0)
        begin : g_first
            assign pv   = sv_reg;
            assign pl   = sl_reg;
            assign plen = slen_reg;
            assign pmid = smid_reg;
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prem[c] = sx_reg[c];
                    pq[c]   = '0;
                    t[c]    = {1'b0, prem[c]};
                end
            end
        end
        else
        begin : g_next
            assign pv   = dv_reg[j-1];
            assign pl   = dl_reg[j-1];
            assign plen = dlen_reg[j-1];
            assign pmid = dmid_reg[j-1];
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prem[c] = drem_reg[j-1][c];
                    pq[c]   = dq_reg[j-1][c];
                    t[c]    = {prem[c], 1'b0};
                end
            end
        end

        always_comb
        begin
            for (int c = 0; c < 3; c++)
                ge[c] = (t[c] >= {1'b0, pl});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j] <= 1'b0;
            else if (advance)
                dv_reg[j] <= pv;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dl_reg[j]   <= pl;
                dlen_reg[j] <= plen;
                dmid_reg[j] <= pmid;
                for (int c = 0; c < 3; c++)
                begin
                    drem_reg[j][c] <= ge[c] ? RW'(t[c] - {1'b0, pl}) : t[c][RW-1:0];
                    dq_reg[j][c]   <= {pq[c][QW-2:0], ge[c]};
                end
            end
        end
    end

    // ---------------- round half up on the remainder ----------------
    logic            rv_reg;
    logic [QW:0]     rq_reg [3];
    logic [LW-1:0]   rlen_reg;
    v3alu_pkg::mid_t rmid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else if (advance)
            rv_reg <= dv_reg[QW-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rlen_reg <= dlen_reg[QW-1];
            rmid_reg <= dmid_reg[QW-1];
            for (int c = 0; c < 3; c++)
                rq_reg[c] <= {1'b0, dq_reg[QW-1][c]}
                           + (QW+1)'({drem_reg[QW-1][c], 1'b0} >= {1'b0, dl_reg[QW-1]});
        end
    end

    // ---------------- sign, saturate, assemble ----------------
    logic [CW:0]   m   [3];
    logic [WW-1:0] nv  [3];
    logic [WW-1:0] fin [3];
    logic          err;
    logic          fv_reg;
    v3alu_pkg::rsp_t res_reg;

    always_comb
    begin
        err = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            m[c] = {{(CW-QW){1'b0}}, rq_reg[c]};
            if (!rmid_reg.neg[c])
                nv[c] = (m[c] > MAGP) ? {1'b0, {(WW-1){1'b1}}} : m[c][WW-1:0];
            else
                nv[c] = (m[c] > MAGN) ? {1'b1, {(WW-1){1'b0}}} : (~m[c][WW-1:0] + 1'b1);
            fin[c] = rmid_reg.vec[c];
        end
        if (rmid_reg.opcode == v3alu_pkg::OP_NORM)
        begin
            if (rmid_reg.zero)
            begin
                err = 1'b1;
                for (int c = 0; c < 3; c++)
                    fin[c] = '0;
            end
            else
            begin
                for (int c = 0; c < 3; c++)
                    fin[c] = nv[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (advance)
            fv_reg <= rv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.rx                <= fin[0];
            res_reg.ry                <= fin[1];
            res_reg.rz                <= fin[2];
            res_reg.length            <= rlen_reg;
            res_reg.zero_length_error <= err;
        end
    end

    assign res_valid = fv_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== rtl/vec3_vector_alu_top.sv =====
// Three-component Q16.16 vector unit: add, sub, multiply, scale, normalize,
// cross product and length, one request per clock while req_ready is high.
// A request passes through the front end, the 64-stage square-root pipeline
// and the per-bit normalize divider behind it, then the output register.
// A new request can be taken every cycle; a stalled output is absorbed by
// a one-entry skid register, after which req_ready drops until the sink
// takes a result. Uses v3alu_pkg and the front, sqrt and div submodules.
`default_nettype none

module vec3_vector_alu_top #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire v3alu_pkg::req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output v3alu_pkg::rsp_t      rsp
);

    logic                       advance;
    logic                       stg_valid;
    logic [v3alu_pkg::NW-1:0]   stg_rad;
    v3alu_pkg::mid_t            stg_mid;
    logic                       root_valid;
    logic [v3alu_pkg::RW-1:0]   root;
    v3alu_pkg::mid_t            root_mid;
    logic                       res_valid;
    v3alu_pkg::rsp_t            res;

    logic                       out_v_reg;
    v3alu_pkg::rsp_t            out_reg;
    logic                       skid_v_reg;
    v3alu_pkg::rsp_t            skid_reg;

    // whole pipeline moves while the skid entry is free
    assign advance   = !skid_v_reg;
    assign req_ready = advance;

    v3alu_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req),
        .stg_valid (stg_valid),
        .stg_rad   (stg_rad),
        .stg_mid   (stg_mid)
    );

    v3alu_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .stg_valid  (stg_valid),
        .stg_rad    (stg_rad),
        .stg_mid    (stg_mid),
        .root_valid (root_valid),
        .root       (root),
        .root_mid   (root_mid)
    );

    v3alu_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .root_valid (root_valid),
        .root       (root),
        .root_mid   (root_mid),
        .res_valid  (res_valid),
        .res        (res)
    );

    // output register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || rsp_ready)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                out_v_reg <= res_valid;
        end
        else if (advance && res_valid)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || rsp_ready)
            out_reg <= skid_v_reg ? skid_reg : res;
        else if (advance && res_valid)
            skid_reg <= res;
    end

    assign rsp_valid = out_v_reg;
    assign rsp       = out_reg;

    // skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry valid without a pending result");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !rsp_ready))
        else $error("skid filled while output was free");

    // zero-vector normalize gives a zero vector and zero length
    a_err_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.zero_length_error) |->
            (rsp.rx == '0 && rsp.ry == '0 && rsp.rz == '0 && rsp.length == '0))
        else $error("zero-length error with nonzero result");

    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && out_v_reg && !rsp_ready) |=> skid_v_reg)
        else $error("skid entry lost under stall");

endmodule

`default_nettype wire

// ===== verif/tb_vec3_vector_alu_top.sv =====
// Self-checking testbench for vec3_vector_alu_top: directed and random requests,
// predicted per request and checked in order against every result.
// Depends on v3alu_pkg and the vec3_vector_alu_top RTL.
`default_nettype none

module tb_vec3_vector_alu_top;

    localparam int WW        = v3alu_pkg::WW;
    localparam int LW        = v3alu_pkg::LW;
    localparam int FRAC      = v3alu_pkg::FRAC_DEF;
    localparam int LATENCY   = 73 + FRAC;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 220;     // per run phase

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    v3alu_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    v3alu_pkg::rsp_t rsp;

    v3alu_pkg::req_t pending_q[$];
    v3alu_pkg::rsp_t expected_rsp_q[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;

    vec3_vector_alu_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // saturate a wide signed value to one word
    function automatic logic [WW-1:0] sat_word(logic signed [127:0] v);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        hi_lim = (128'sd1 <<< (WW - 1)) - 1;
        lo_lim = -(128'sd1 <<< (WW - 1));
        if (v > hi_lim)
            return hi_lim[WW-1:0];
        if (v < lo_lim)
            return lo_lim[WW-1:0];
        return v[WW-1:0];
    endfunction

    // product rounded to nearest, ties up, then saturated
    function automatic logic [WW-1:0] round_sat(logic signed [127:0] v);
        return sat_word((v + (128'sd1 <<< (FRAC - 1))) >>> FRAC);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [127:0] s);
        logic [63:0]  root;
        logic [127:0] trial;
        root = '0;
        for (int i = 63; i >= 0; i--)
        begin
            trial = {64'd0, root | (64'd1 << i)};
            if (trial * trial <= s)
                root = trial[63:0];
        end
        return root;
    endfunction

    // one normalized component: |a| * 2^(FRAC+k) / root, ties away from zero
    function automatic logic [WW-1:0] unit_comp(logic signed [127:0] a, int k,
                                                logic [127:0] root);
        logic          neg;
        logic [127:0]  mag;
        logic [127:0]  num;
        logic [127:0]  quo;
        logic [127:0]  rem;
        neg = a < 0;
        mag = neg ? -a : a;
        num = mag << (FRAC + k);
        quo = num / root;
        rem = num % root;
        if ((rem << 1) >= root)
            quo = quo + 1;
        return sat_word(neg ? -$signed(quo) : $signed(quo));
    endfunction

    function automatic v3alu_pkg::rsp_t vec_alu_predict(v3alu_pkg::req_t r);
        v3alu_pkg::rsp_t     res;
        logic signed [127:0] ax, ay, az, bx, by, bz, sc;
        logic [127:0]        sumsq;
        logic [63:0]         len;
        logic [127:0]        root;
        int                  lz;
        int                  k;
        ax = r.ax; ay = r.ay; az = r.az;
        bx = r.bx; by = r.by; bz = r.bz; sc = r.scale;
        res = '0;
        sumsq = ax * ax + ay * ay + az * az;
        len = int_sqrt(sumsq);
        res.length = (len > 64'h7fff_ffff) ? 31'h7fff_ffff : len[LW-1:0];
        case (r.opcode)
            v3alu_pkg::OP_ADD:
            begin
                res.rx = sat_word(ax + bx);
                res.ry = sat_word(ay + by);
                res.rz = sat_word(az + bz);
            end
            v3alu_pkg::OP_SUB:
            begin
                res.rx = sat_word(ax - bx);
                res.ry = sat_word(ay - by);
                res.rz = sat_word(az - bz);
            end
            v3alu_pkg::OP_MUL:
            begin
                res.rx = round_sat(ax * bx);
                res.ry = round_sat(ay * by);
                res.rz = round_sat(az * bz);
            end
            v3alu_pkg::OP_SCALE:
            begin
                res.rx = round_sat(ax * sc);
                res.ry = round_sat(ay * sc);
                res.rz = round_sat(az * sc);
            end
            v3alu_pkg::OP_NORM:
            begin
                if (sumsq == 0)
                    res.zero_length_error = 1'b1;
                else
                begin
                    lz = 0;
                    while (lz < 127 && !sumsq[127 - lz])
                        lz++;
                    k = lz / 2;
                    root = {64'd0, int_sqrt(sumsq << (2 * k))};
                    res.rx = unit_comp(ax, k, root);
                    res.ry = unit_comp(ay, k, root);
                    res.rz = unit_comp(az, k, root);
                end
            end
            v3alu_pkg::OP_CROSS:
            begin
                res.rx = round_sat(ay * bz - az * by);
                res.ry = round_sat(az * bx - ax * bz);
                res.rz = round_sat(ax * by - ay * bx);
            end
            default: ;  // length and the unused opcode give a zero vector
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [WW-1:0] got, logic [WW-1:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, field, got, want);
        mismatches++;
    endtask

    // random word: full range, small magnitudes or extremes
    function automatic logic [WW-1:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3, 4, 5: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic v3alu_pkg::req_t make_req(logic [2:0] op, logic [WW-1:0] a,
                                                 logic [WW-1:0] b, logic [WW-1:0] s);
        v3alu_pkg::req_t r;
        r.opcode = op;
        r.ax = a; r.ay = a; r.az = a;
        r.bx = b; r.by = b; r.bz = b;
        r.scale = s;
        return r;
    endfunction

    function automatic v3alu_pkg::req_t rand_req();
        v3alu_pkg::req_t r;
        r.opcode = 3'($urandom_range(7));
        r.ax = rand_word(); r.ay = rand_word(); r.az = rand_word();
        r.bx = rand_word(); r.by = rand_word(); r.bz = rand_word();
        r.scale = rand_word();
        return r;
    endfunction

    // driver: offer the next pending request, record predictions on acceptance
    always @(posedge clk)
    begin
        if (rst_n && (!req_valid || req_ready))
        begin
            if (req_valid)
                expected_rsp_q.push_back(vec_alu_predict(req));
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req       <= pending_q.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // monitor: check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        v3alu_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                    report_mismatch("unexpected result", rsp.rx, '0);
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.rx !== want.rx) report_mismatch("rx", rsp.rx, want.rx);
                    if (rsp.ry !== want.ry) report_mismatch("ry", rsp.ry, want.ry);
                    if (rsp.rz !== want.rz) report_mismatch("rz", rsp.rz, want.rz);
                    if (rsp.length !== want.length)
                        report_mismatch("length", WW'(rsp.length), WW'(want.length));
                    if (rsp.zero_length_error !== want.zero_length_error)
                        report_mismatch("zero_length_error", WW'(rsp.zero_length_error),
                                        WW'(want.zero_length_error));
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic run_phase(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < N_RANDOM; i++)
            pending_q.push_back(rand_req());
        wait (pending_q.size() == 0 && !req_valid);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: every opcode at the field extremes, zero normalize, unused opcode
        for (int op = 0; op < 8; op++)
        begin
            pending_q.push_back(make_req(3'(op), 32'h7fff_ffff, 32'h7fff_ffff,
                                         32'h7fff_ffff));
            pending_q.push_back(make_req(3'(op), 32'h8000_0000, 32'h7fff_ffff,
                                         32'h8000_0000));
        end
        pending_q.push_back(make_req(v3alu_pkg::OP_NORM, '0, 32'h1234_5678, '0));
        pending_q.push_back(make_req(v3alu_pkg::OP_NORM, 32'h0000_0001, '0, '0));
        pending_q.push_back(make_req(v3alu_pkg::OP_NORM, 32'hffff_ffff, '0, '0));
        pending_q.push_back(make_req(v3alu_pkg::OP_MUL, 32'h0000_8000, 32'h0000_0001, '0));
        pending_q.push_back(make_req(v3alu_pkg::OP_MUL, 32'hffff_8000, 32'h0000_0001, '0));
        pending_q.push_back(make_req(v3alu_pkg::OP_SCALE, 32'h0001_8000, '0, 32'hffff_0000));
        pending_q.push_back(make_req(v3alu_pkg::OP_CROSS, 32'h0001_0000, 32'h0002_0000, '0));
        pending_q.push_back(make_req(v3alu_pkg::OP_LEN, 32'h0003_0000, '0, '0));

        run_phase(0, 0);
        run_phase(74, 0);
        run_phase(0, 74);
        run_phase(36, 36);

        wait (expected_rsp_q.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0 && expected_rsp_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
